// File: src/percent_encode_decode_stream_top_macros.svh
// assertion macros shared by the percent codec modules
`ifndef PERCENT_ENCODE_DECODE_STREAM_TOP_MACROS_SVH
`define PERCENT_ENCODE_DECODE_STREAM_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define PCT_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("percent codec assertion failed");
// next-cycle implication, disabled during reset
`define PCT_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("percent codec assertion failed");
`else
`define PCT_ASSERT_IMP(label, clk, rst_n, lhs, rhs)
`define PCT_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)
`endif

`endif

// File: src/pct_pkg.sv
// types, constants and character helpers for the percent codec
package pct_pkg;

    localparam int PCT_QUEUE_DEPTH = 2;

    localparam logic [7:0] PCT_CHAR = 8'h25;

    localparam logic [7:0] HEX_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    // input transaction
    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_last;
    } char_t;

    // output transaction
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       stream_end;
    } code_t;

    // one classified item: one to three bytes to emit
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      n_bytes;
        logic            last;
    } job_t;

    function automatic logic is_hex(input logic [7:0] c);
        logic r;
        r = c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
        return r;
    endfunction

    // letters sit at 0x41 and 0x61, so their value is the low nibble plus nine
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [3:0] r;
        r = c[6] ? (c[3:0] + 4'd9) : c[3:0];
        return r;
    endfunction

    function automatic logic passes_plain(input logic [7:0] c);
        logic r;
        r = c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
                      8'h2D, 8'h5F, 8'h2E, 8'h20};
        return r;
    endfunction

endpackage

// File: src/pct_front.sv
// front end: mode register, decode state and classification into byte jobs
`include "percent_encode_decode_stream_top_macros.svh"

module pct_front
    import pct_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  char_valid,
    output logic  char_stall,
    input  char_t char_data,
    input  logic  mode_we,
    input  logic  mode_wdata,
    input  logic  q_full,
    output logic  q_push,
    output job_t  q_job
);

    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_PCT   = 2'd1,
        PEND_DIGIT = 2'd2
    } pend_t;

    logic       mode_reg;
    pend_t      pend_reg, pend_next;
    logic [7:0] digit_reg, digit_next;
    logic       accept;
    logic       fresh;
    logic [1:0] n;
    logic [7:0] b;

    assign char_stall = q_full;
    assign accept     = char_valid && !q_full;
    assign b          = char_data.data_byte;

    // classify one byte and build its output job
    always_comb
    begin
        pend_next     = pend_reg;
        digit_next    = digit_reg;
        fresh         = 1'b0;
        n             = 2'd0;
        q_job.bytes   = '0;
        q_job.last    = char_data.stream_last;
        if (!mode_reg)
        begin
            if (passes_plain(b))
            begin
                q_job.bytes[n] = b;
                n = n + 2'd1;
            end
            else
            begin
                q_job.bytes[n] = PCT_CHAR;
                n = n + 2'd1;
                q_job.bytes[n] = HEX_DIGITS[b[7:4]];
                n = n + 2'd1;
                q_job.bytes[n] = HEX_DIGITS[b[3:0]];
                n = n + 2'd1;
            end
            pend_next = PEND_NONE;
        end
        else
        begin
            case (pend_reg)
                PEND_PCT:
                begin
                    if (is_hex(b))
                    begin
                        pend_next  = PEND_DIGIT;
                        digit_next = b;
                    end
                    else
                    begin
                        q_job.bytes[n] = PCT_CHAR;
                        n = n + 2'd1;
                        fresh = 1'b1;
                    end
                end
                PEND_DIGIT:
                begin
                    if (is_hex(b) && is_hex(digit_reg))
                    begin
                        q_job.bytes[n] = {nibble_of(digit_reg), nibble_of(b)};
                        n = n + 2'd1;
                        pend_next = PEND_NONE;
                    end
                    else
                    begin
                        q_job.bytes[n] = PCT_CHAR;
                        n = n + 2'd1;
                        q_job.bytes[n] = digit_reg;
                        n = n + 2'd1;
                        fresh = 1'b1;
                    end
                end
                default:
                begin
                    fresh = 1'b1;
                end
            endcase
            // byte taken fresh or reprocessed after a broken escape
            if (fresh)
            begin
                if (b == PCT_CHAR)
                begin
                    pend_next = PEND_PCT;
                end
                else
                begin
                    q_job.bytes[n] = b;
                    n = n + 2'd1;
                    pend_next = PEND_NONE;
                end
            end
            // flush held escape at end of stream
            if (char_data.stream_last)
            begin
                if (pend_next != PEND_NONE)
                begin
                    q_job.bytes[n] = PCT_CHAR;
                    n = n + 2'd1;
                end
                if (pend_next == PEND_DIGIT)
                begin
                    q_job.bytes[n] = digit_next;
                    n = n + 2'd1;
                end
                pend_next = PEND_NONE;
            end
        end
        if (char_data.stream_last || pend_next != PEND_DIGIT)
        begin
            digit_next = '0;
        end
        q_job.n_bytes = n;
    end

    assign q_push = accept && (n != 2'd0);

    // mode and decode state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            pend_reg  <= PEND_NONE;
            digit_reg <= '0;
        end
        else if (mode_we)
        begin
            mode_reg  <= mode_wdata;
            pend_reg  <= PEND_NONE;
            digit_reg <= '0;
        end
        else if (accept)
        begin
            pend_reg  <= pend_next;
            digit_reg <= digit_next;
        end
    end

    `PCT_ASSERT_IMP(a_last_pushes, clk, rst_n, accept && char_data.stream_last, q_push)
    `PCT_ASSERT_NEXT(a_cfg_clears, clk, rst_n, mode_we, pend_reg == PEND_NONE)
    `PCT_ASSERT_IMP(a_digit_held, clk, rst_n, pend_reg == PEND_DIGIT, is_hex(digit_reg))

endmodule

// File: src/pct_fifo.sv
// short job queue between front end and back end
`include "percent_encode_decode_stream_top_macros.svh"

module pct_fifo
    import pct_pkg::*;
#(
    parameter int DEPTH = PCT_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = mem_reg[rd_ptr_reg];

    // storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    `PCT_ASSERT_IMP(a_no_overflow, clk, rst_n, push, !full)

endmodule

// File: src/pct_back.sv
// back end: emits the bytes of each job, one per cycle while code_stall is low
`include "percent_encode_decode_stream_top_macros.svh"

module pct_back
    import pct_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  q_empty,
    output logic  q_pop,
    input  job_t  q_job,
    output logic  code_valid,
    input  logic  code_stall,
    output code_t code_data
);

    job_t       cur_reg;
    logic       busy_reg;
    logic [1:0] idx_reg;
    logic       fire, done, load;

    // current byte and its flags
    assign code_valid           = busy_reg;
    assign code_data.out_byte   = cur_reg.bytes[idx_reg];
    assign code_data.run_last   = (idx_reg == cur_reg.n_bytes - 2'd1);
    assign code_data.stream_end = code_data.run_last && cur_reg.last;

    assign fire  = busy_reg && !code_stall;
    assign done  = fire && code_data.run_last;
    assign load  = (!busy_reg || done) && !q_empty;
    assign q_pop = load;

    // job register, no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= q_job;
        end
    end

    // emit control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (fire)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    `PCT_ASSERT_NEXT(a_hold_stall, clk, rst_n, busy_reg && code_stall,
        $stable(cur_reg) && $stable(idx_reg) && busy_reg)
    `PCT_ASSERT_IMP(a_idx_range, clk, rst_n, busy_reg,
        cur_reg.n_bytes != 2'd0 && idx_reg < cur_reg.n_bytes)

endmodule

// File: src/percent_encode_decode_stream_top.sv
// Percent encode/decode byte stream codec, top level.
// Each job is registered in the job queue, then in the back end job register.
// Throughput: one output byte per cycle while code_stall is low; an item of n bytes
// (1 to 3) holds the back end until all are sent; items with no output are not queued.
// Input stalls only while the job queue (QUEUE_DEPTH entries) is full.
// Reset: encode mode, nothing pending, queue and output empty.
module percent_encode_decode_stream_top
    import pct_pkg::*;
#(
    parameter int QUEUE_DEPTH = PCT_QUEUE_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  char_valid,
    output logic  char_stall,
    input  char_t char_data,
    output logic  code_valid,
    input  logic  code_stall,
    output code_t code_data,
    input  logic  mode_we,
    input  logic  mode_wdata
);

    logic q_push, q_full, q_pop, q_empty;
    job_t push_job, pop_job;

    // classification
    pct_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data),
        .mode_we    (mode_we),
        .mode_wdata (mode_wdata),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_job      (push_job)
    );

    // job queue
    pct_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    // byte emission
    pct_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .q_job      (pop_job),
        .code_valid (code_valid),
        .code_stall (code_stall),
        .code_data  (code_data)
    );

endmodule
